/* rtl/frd_pkg.sv */
// Shared types and constants of the flood relay with duplicate cache and send rate limit.
package frd_pkg;

	// Request kinds carried on the input tuser.
	localparam logic [1:0] REQ_RX   = 2'd0;
	localparam logic [1:0] REQ_SEND = 2'd1;

	// Result status codes carried on the output tuser.
	localparam logic [2:0] ST_ACCEPTED     = 3'd0;
	localparam logic [2:0] ST_SENT         = 3'd1;
	localparam logic [2:0] ST_BAD_LENGTH   = 3'd2;
	localparam logic [2:0] ST_BAD_TYPE     = 3'd3;
	localparam logic [2:0] ST_DUPLICATE    = 3'd4;
	localparam logic [2:0] ST_RATE_LIMITED = 3'd5;
	localparam logic [2:0] ST_CLEARED      = 3'd6;

	// Configuration register indexes.
	localparam logic [2:0] REG_WINDOW   = 3'd0;
	localparam logic [2:0] REG_MSG_TYPE = 3'd1;
	localparam logic [2:0] REG_EXP_LEN  = 3'd2;
	localparam logic [2:0] REG_INIT_TTL = 3'd3;
	localparam logic [2:0] REG_REPEATS  = 3'd4;

	// Configuration reset values.
	localparam logic [30:0] WINDOW_RESET   = 31'd40000;
	localparam logic [7:0]  MSG_TYPE_RESET = 8'h42;
	localparam logic [7:0]  EXP_LEN_RESET  = 8'd12;
	localparam logic [7:0]  INIT_TTL_RESET = 8'd4;
	localparam logic [3:0]  REPEATS_RESET  = 4'd3;

	// Which comparison the shared unit is making.
	typedef enum logic {
		CMP_ID_MATCH,
		CMP_SLOT_AGE
	} cmp_mode_t;

	// Result of the shared compare unit.
	typedef struct packed {
		logic eq;   // operands are equal
		logic lt;   // a - b (mod 2^32) is below the window
	} cmp_res_t;

endpackage

/* rtl/frd_id_mem.sv */
// Ring store of recently seen message ids, one write and one registered read port.
module frd_id_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/frd_cmp_unit.sv */
// Shared 32-bit compare unit: equality for the id scan, wrapped age test for the slot scan.
module frd_cmp_unit (
	input  frd_pkg::cmp_mode_t mode,
	input  logic [31:0]        a,
	input  logic [31:0]        b,
	input  logic [30:0]        window,
	output frd_pkg::cmp_res_t  res
);

	logic [31:0] diff;

	assign diff = a - b;

	always_comb begin
		res.eq = 1'b0;
		res.lt = 1'b0;
		case (mode)
			frd_pkg::CMP_ID_MATCH: res.eq = (a == b);
			frd_pkg::CMP_SLOT_AGE: res.lt = (diff < {1'b0, window});
			default: res.eq = 1'b0;
		endcase
	end

endmodule

/* rtl/flood_relay_dedup_rate_limit_unit.sv */
// Top level of the flood relay: sequencer, configuration, send-slot history and result register.
//
//  Channel  | Handshake                   | Payload
//  ---------+-----------------------------+---------------------------------------------
//  input    | s_axis_tvalid/s_axis_tready | tuser req_type; tdata time_ms .. hops_left
//  result   | m_axis_tvalid/m_axis_tready | tuser status; tdata tx_valid .. notify_time
//  config   | cfg_we (no back-pressure)   | cfg_index, cfg_data
//
// A received packet that passes the length and type checks runs the id scan: each stored id
// is read in turn through the single registered read port and compared in the shared unit.
// A local send runs the slot scan, one slot age test a cycle in the same unit. Other items
// go straight to the final state. The input is ready only in the idle state. Reset clears
// the slot valid bits, the pointers and the fill count of the id store; ids beyond the fill
// count read as zero. A stalled result beat holds the block in its final state until taken.
module flood_relay_dedup_rate_limit_unit #(
	parameter int HISTORY_DEPTH = 32,
	parameter int SEND_SLOTS    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input beat.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
	input  logic [87:0] s_axis_tdata,   // time_ms, packet_length, packet_type, message_id, hops_left
	// Result beat.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [2:0]  m_axis_tuser,   // [2:0] status
	output logic [87:0] m_axis_tdata,   // tx_valid, tx_type, tx_id, tx_hops, tx_copies,
	                                    // notify_start, notify_time, two zero bits
	// Configuration writes.
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [30:0] cfg_data
);

	localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int FW = $clog2(HISTORY_DEPTH + 1);
	localparam int SW = (SEND_SLOTS > 1) ? $clog2(SEND_SLOTS) : 1;
	localparam int RW = $clog2(SEND_SLOTS + 1);
	localparam logic [AW-1:0] ID_LAST   = AW'(HISTORY_DEPTH - 1);
	localparam logic [FW-1:0] ID_FULL   = FW'(HISTORY_DEPTH);
	localparam logic [SW-1:0] SLOT_LAST = SW'(SEND_SLOTS - 1);
	localparam logic [RW-1:0] SLOT_ALL  = RW'(SEND_SLOTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ID_SCAN,
		S_ID_DRAIN,
		S_SLOT_SCAN,
		S_FINISH
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [30:0] window_q;
	logic [7:0]  msg_type_q;
	logic [7:0]  exp_len_q;
	logic [7:0]  init_ttl_q;
	logic [3:0]  repeats_q;

	// Latched input item.
	logic [1:0]  req_q;
	logic [31:0] time_q;
	logic [7:0]  plen_q;
	logic [7:0]  ptype_q;
	logic [31:0] id_q;
	logic [7:0]  hops_q;

	// Id store control.
	logic [AW-1:0] id_wptr_q;
	logic [FW-1:0] id_fill_q;
	logic [AW-1:0] scan_idx_q;
	logic          vld_s1;
	logic [AW-1:0] idx_s1;
	logic          hit_q;
	logic [31:0]   mem_rdata;
	logic [31:0]   entry;

	// Send-slot history.
	logic [31:0]           send_times_q [SEND_SLOTS];
	logic [SEND_SLOTS-1:0] slot_valid_q;
	logic [SW-1:0]         send_ptr_q;
	logic [SW-1:0]         slot_idx_q;
	logic [RW-1:0]         recent_q;

	logic notify_active_q;

	// Result register.
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic        tx_valid_q;
	logic [7:0]  tx_type_q;
	logic [31:0] tx_id_q;
	logic [7:0]  tx_hops_q;
	logic [3:0]  tx_copies_q;
	logic        notify_start_q;
	logic [31:0] notify_time_q;

	// Shared compare unit.
	frd_pkg::cmp_mode_t cmp_mode;
	logic [31:0]        cmp_a;
	logic [31:0]        cmp_b;
	frd_pkg::cmp_res_t  cmp_res;

	// Decision made in the final state.
	logic       out_free;
	logic       commit;
	logic       len_ok;
	logic       type_ok;
	logic       send_ok;
	logic       store_id;
	logic       store_time;
	logic [2:0] status_d;

	logic [31:0] in_time;
	logic [7:0]  in_plen;
	logic [7:0]  in_ptype;

	assign in_time  = s_axis_tdata[31:0];
	assign in_plen  = s_axis_tdata[39:32];
	assign in_ptype = s_axis_tdata[47:40];

	assign s_axis_tready = (state_q == S_IDLE);

	// Entries past the fill count have never been written and are read here as zero.
	assign entry = (FW'(idx_s1) < id_fill_q) ? mem_rdata : 32'd0;

	frd_id_mem #(
		.DEPTH (HISTORY_DEPTH),
		.AW    (AW)
	) u_id_mem (
		.clk   (clk),
		.we    (store_id),
		.waddr (id_wptr_q),
		.wdata (id_q),
		.raddr (scan_idx_q),
		.rdata (mem_rdata)
	);

	always_comb begin
		if (state_q == S_SLOT_SCAN) begin
			cmp_mode = frd_pkg::CMP_SLOT_AGE;
			cmp_a    = time_q;
			cmp_b    = send_times_q[slot_idx_q];
		end else begin
			cmp_mode = frd_pkg::CMP_ID_MATCH;
			cmp_a    = id_q;
			cmp_b    = entry;
		end
	end

	frd_cmp_unit u_cmp (
		.mode   (cmp_mode),
		.a      (cmp_a),
		.b      (cmp_b),
		.window (window_q),
		.res    (cmp_res)
	);

	// Outcome of the item, valid in the final state.
	always_comb begin
		out_free   = !out_valid_q || m_axis_tready;
		commit     = (state_q == S_FINISH) && out_free;
		len_ok     = (plen_q == exp_len_q);
		type_ok    = (ptype_q == msg_type_q);
		send_ok    = (recent_q < SLOT_ALL);
		store_id   = 1'b0;
		store_time = 1'b0;
		status_d   = frd_pkg::ST_CLEARED;
		case (req_q)
			frd_pkg::REQ_RX: begin
				if (!len_ok) begin
					status_d = frd_pkg::ST_BAD_LENGTH;
				end else if (!type_ok) begin
					status_d = frd_pkg::ST_BAD_TYPE;
				end else if (hit_q) begin
					status_d = frd_pkg::ST_DUPLICATE;
				end else begin
					status_d = frd_pkg::ST_ACCEPTED;
					store_id = commit;
				end
			end
			frd_pkg::REQ_SEND: begin
				if (send_ok) begin
					status_d   = frd_pkg::ST_SENT;
					store_id   = commit;
					store_time = commit;
				end else begin
					status_d = frd_pkg::ST_RATE_LIMITED;
				end
			end
			default: status_d = frd_pkg::ST_CLEARED;
		endcase
	end

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= frd_pkg::WINDOW_RESET;
			msg_type_q <= frd_pkg::MSG_TYPE_RESET;
			exp_len_q  <= frd_pkg::EXP_LEN_RESET;
			init_ttl_q <= frd_pkg::INIT_TTL_RESET;
			repeats_q  <= frd_pkg::REPEATS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				frd_pkg::REG_WINDOW:   window_q   <= cfg_data;
				frd_pkg::REG_MSG_TYPE: msg_type_q <= cfg_data[7:0];
				frd_pkg::REG_EXP_LEN:  exp_len_q  <= cfg_data[7:0];
				frd_pkg::REG_INIT_TTL: init_ttl_q <= cfg_data[7:0];
				frd_pkg::REG_REPEATS:  repeats_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Send times are only ever read where the slot's valid bit is set.
	always_ff @(posedge clk) begin
		if (store_time) begin
			send_times_q[send_ptr_q] <= time_q;
		end
	end

	// Item payload latched on acceptance.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_q   <= s_axis_tuser;
			time_q  <= in_time;
			plen_q  <= in_plen;
			ptype_q <= in_ptype;
			id_q    <= s_axis_tdata[79:48];
			hops_q  <= s_axis_tdata[87:80];
		end
	end

	// Sequencer with the pointers, history bookkeeping and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			id_wptr_q       <= '0;
			id_fill_q       <= '0;
			scan_idx_q      <= '0;
			vld_s1          <= 1'b0;
			idx_s1          <= '0;
			hit_q           <= 1'b0;
			slot_valid_q    <= '0;
			send_ptr_q      <= '0;
			slot_idx_q      <= '0;
			recent_q        <= '0;
			notify_active_q <= 1'b0;
			out_valid_q     <= 1'b0;
			status_q        <= frd_pkg::ST_ACCEPTED;
			tx_valid_q      <= 1'b0;
			tx_type_q       <= '0;
			tx_id_q         <= '0;
			tx_hops_q       <= '0;
			tx_copies_q     <= '0;
			notify_start_q  <= 1'b0;
			notify_time_q   <= '0;
		end else begin
			// A new result loaded in the same cycle keeps the valid high.
			if (m_axis_tvalid && m_axis_tready && !commit) begin
				out_valid_q <= 1'b0;
			end

			// The read stage follows the address in the next cycle.
			vld_s1 <= (state_q == S_ID_SCAN);
			idx_s1 <= scan_idx_q;
			if (vld_s1 && cmp_res.eq) begin
				hit_q <= 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					scan_idx_q <= '0;
					slot_idx_q <= '0;
					recent_q   <= '0;
					hit_q      <= 1'b0;
					if (s_axis_tvalid) begin
						if (s_axis_tuser == frd_pkg::REQ_RX && in_plen == exp_len_q
						    && in_ptype == msg_type_q) begin
							state_q <= S_ID_SCAN;
						end else if (s_axis_tuser == frd_pkg::REQ_SEND) begin
							state_q <= S_SLOT_SCAN;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_ID_SCAN: begin
					if (scan_idx_q == ID_LAST) begin
						state_q <= S_ID_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				S_ID_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_SLOT_SCAN: begin
					if (slot_valid_q[slot_idx_q] && cmp_res.lt) begin
						recent_q <= recent_q + 1'b1;
					end
					if (slot_idx_q == SLOT_LAST) begin
						state_q <= S_FINISH;
					end else begin
						slot_idx_q <= slot_idx_q + 1'b1;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q        <= S_IDLE;
						out_valid_q    <= 1'b1;
						status_q       <= status_d;
						tx_valid_q     <= 1'b0;
						tx_type_q      <= '0;
						tx_id_q        <= '0;
						tx_hops_q      <= '0;
						tx_copies_q    <= '0;
						notify_start_q <= 1'b0;
						notify_time_q  <= '0;
						if (store_id) begin
							id_wptr_q <= (id_wptr_q == ID_LAST) ? '0 : id_wptr_q + 1'b1;
							if (id_fill_q != ID_FULL) begin
								id_fill_q <= id_fill_q + 1'b1;
							end
						end
						if (status_d == frd_pkg::ST_ACCEPTED) begin
							if (!notify_active_q) begin
								notify_active_q <= 1'b1;
								notify_start_q  <= 1'b1;
								notify_time_q   <= time_q;
							end
							if (hops_q != 8'd0) begin
								tx_valid_q  <= 1'b1;
								tx_type_q   <= ptype_q;
								tx_id_q     <= id_q;
								tx_hops_q   <= hops_q - 8'd1;
								tx_copies_q <= 4'd1;
							end
						end else if (status_d == frd_pkg::ST_SENT) begin
							slot_valid_q[send_ptr_q] <= 1'b1;
							send_ptr_q  <= (send_ptr_q == SLOT_LAST) ? '0 : send_ptr_q + 1'b1;
							tx_valid_q  <= 1'b1;
							tx_type_q   <= msg_type_q;
							tx_id_q     <= id_q;
							tx_hops_q   <= init_ttl_q;
							tx_copies_q <= repeats_q;
						end else if (status_d == frd_pkg::ST_CLEARED) begin
							notify_active_q <= 1'b0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {2'b00, notify_time_q, notify_start_q, tx_copies_q, tx_hops_q,
	                        tx_id_q, tx_type_q, tx_valid_q};

endmodule

/* verif/tb.sv */
// Self-checking testbench for the flood relay unit: directed corner cases, then random traffic.
module tb;

	localparam int HIST        = 32;
	localparam int SLOTS       = 4;
	// No beat is ever expected to take longer than this number of quiet cycles.
	localparam int QUIET_LIMIT = 2000;

	// Request kinds beyond those that the package names. Both clear the notification.
	localparam logic [1:0] REQ_CLEAR = 2'd2;
	localparam logic [1:0] REQ_SPARE = 2'd3;

	// One input beat, as the fields of the request.
	typedef struct packed {
		logic [1:0]  req;
		logic [31:0] now;
		logic [7:0]  len;
		logic [7:0]  ptype;
		logic [31:0] id;
		logic [7:0]  hops;
	} relay_req_t;

	// One result beat, as the fields of the answer.
	typedef struct packed {
		logic [2:0]  status;
		logic        tx_valid;
		logic [7:0]  tx_type;
		logic [31:0] tx_id;
		logic [7:0]  tx_hops;
		logic [3:0]  tx_copies;
		logic        notify_start;
		logic [31:0] notify_time;
	} relay_res_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [1:0]  s_axis_tuser  = '0;   // [1:0] req_type
	logic [87:0] s_axis_tdata  = '0;   // time_ms, packet_length, packet_type, message_id, hops_left
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [2:0]  m_axis_tuser;         // [2:0] status
	logic [87:0] m_axis_tdata;         // tx_valid, tx_type, tx_id, tx_hops, tx_copies,
	                                   // notify_start, notify_time, two zero bits
	logic        cfg_we        = 1'b0;
	logic [2:0]  cfg_index     = '0;
	logic [30:0] cfg_data      = '0;

	flood_relay_dedup_rate_limit_unit #(
		.HISTORY_DEPTH(HIST),
		.SEND_SLOTS   (SLOTS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	// Our own copy of the configuration registers.
	logic [30:0] cfg_win;
	logic [7:0]  cfg_mtype;
	logic [7:0]  cfg_elen;
	logic [7:0]  cfg_ttl;
	logic [3:0]  cfg_reps;

	// Our own copy of the block's state: the ring of seen ids, the send-time history and
	// whether a notification is running.
	logic [31:0] seen_ids [HIST];
	int unsigned seen_wr;
	logic [31:0] slot_time [SLOTS];
	bit          slot_live [SLOTS];
	int unsigned slot_wr;
	bit          notify_live;

	// Answers still owed by the block, oldest first.
	relay_res_t  pending_results [$];
	// Ids used lately, from which the random traffic draws its duplicates.
	logic [31:0] recent_ids [$];
	logic [31:0] clock_ms;

	bit          gaps_on;
	int unsigned stall_left;
	int unsigned quiet_cycles;
	int          n_fail;
	int          n_items;
	int          n_results;
	int          n_relayed;
	int          n_sent;
	int          n_limited;
	int          n_dups;
	int          n_rejects;
	int          n_notify;

	// Works out the answer to one accepted request and moves our state on, as the block must.
	function automatic relay_res_t relay_predict(relay_req_t q);
		relay_res_t  r;
		bit          known;
		int unsigned recent;
		logic [31:0] age;
		r      = '0;
		known  = 1'b0;
		recent = 0;
		case (q.req)
			frd_pkg::REQ_RX: begin
				if (q.len != cfg_elen) begin
					r.status = frd_pkg::ST_BAD_LENGTH;
				end else if (q.ptype != cfg_mtype) begin
					r.status = frd_pkg::ST_BAD_TYPE;
				end else begin
					foreach (seen_ids[i])
						if (seen_ids[i] == q.id)
							known = 1'b1;
					if (known) begin
						r.status = frd_pkg::ST_DUPLICATE;
					end else begin
						seen_ids[seen_wr] = q.id;
						seen_wr = (seen_wr + 1) % HIST;
						r.status = frd_pkg::ST_ACCEPTED;
						if (!notify_live) begin
							notify_live    = 1'b1;
							r.notify_start = 1'b1;
							r.notify_time  = q.now;
						end
						// A packet whose hop count is spent is taken in but not passed on.
						if (q.hops != 8'd0) begin
							r.tx_valid  = 1'b1;
							r.tx_type   = q.ptype;
							r.tx_id     = q.id;
							r.tx_hops   = q.hops - 8'd1;
							r.tx_copies = 4'd1;
						end
					end
				end
			end
			frd_pkg::REQ_SEND: begin
				// A slot counts against the limit only once written and while younger than
				// the window; ages are taken modulo 2^32 so the clock may wrap.
				foreach (slot_live[i]) begin
					age = q.now - slot_time[i];
					if (slot_live[i] && age < {1'b0, cfg_win})
						recent++;
				end
				if (recent >= SLOTS) begin
					r.status = frd_pkg::ST_RATE_LIMITED;
				end else begin
					seen_ids[seen_wr] = q.id;
					seen_wr = (seen_wr + 1) % HIST;
					slot_time[slot_wr] = q.now;
					slot_live[slot_wr] = 1'b1;
					slot_wr = (slot_wr + 1) % SLOTS;
					r.status    = frd_pkg::ST_SENT;
					r.tx_valid  = 1'b1;
					r.tx_type   = cfg_mtype;
					r.tx_id     = q.id;
					r.tx_hops   = cfg_ttl;
					r.tx_copies = cfg_reps;
				end
			end
			default: begin
				// Both the clear code and the spare code end any running notification.
				notify_live = 1'b0;
				r.status    = frd_pkg::ST_CLEARED;
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			n_fail++;
		end
	endfunction

	function automatic relay_req_t rx_item(logic [31:0] now, logic [7:0] len, logic [7:0] ptype,
			logic [31:0] id, logic [7:0] hops);
		return '{frd_pkg::REQ_RX, now, len, ptype, id, hops};
	endfunction

	function automatic relay_req_t send_req(logic [31:0] now, logic [31:0] id);
		return '{frd_pkg::REQ_SEND, now, 8'h00, 8'h00, id, 8'h00};
	endfunction

	function automatic relay_req_t clear_req(logic [1:0] kind);
		return '{kind, 32'h0, 8'h00, 8'h00, 32'h0, 8'h00};
	endfunction

	// Offers one request beat and waits until the block takes it. The valid is left high
	// afterwards, so back-to-back beats never lower and raise it within one time step; it
	// is only dropped for an idle burst or when the traffic stops.
	task automatic send_item(input relay_req_t q);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= q.req;
		s_axis_tdata  <= {q.hops, q.id, q.ptype, q.len, q.now};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_results.push_back(relay_predict(q));
		n_items++;
	endtask

	// Stops offering requests and waits until every owed answer has come back. Each request
	// gives exactly one answer, so an empty queue means the block is idle.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Writes one configuration register; only called while the block is idle.
	task automatic write_reg(input logic [2:0] idx, input logic [30:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			frd_pkg::REG_WINDOW:   cfg_win   = value;
			frd_pkg::REG_MSG_TYPE: cfg_mtype = value[7:0];
			frd_pkg::REG_EXP_LEN:  cfg_elen  = value[7:0];
			frd_pkg::REG_INIT_TTL: cfg_ttl   = value[7:0];
			frd_pkg::REG_REPEATS:  cfg_reps  = value[3:0];
			default: ;
		endcase
	endtask

	// Receive side: checks every result beat against the oldest owed answer and throttles
	// the ready line in random bursts while idling is enabled.
	always @(posedge clk) begin
		relay_res_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left    = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					$error("result beat with no request outstanding, status %0d", m_axis_tuser);
					n_fail++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", 32'(want.status), 32'(m_axis_tuser));
					check_field("tx_valid", 32'(want.tx_valid), 32'(m_axis_tdata[0]));
					check_field("tx_type", 32'(want.tx_type), 32'(m_axis_tdata[8:1]));
					check_field("tx_id", want.tx_id, m_axis_tdata[40:9]);
					check_field("tx_hops", 32'(want.tx_hops), 32'(m_axis_tdata[48:41]));
					check_field("tx_copies", 32'(want.tx_copies), 32'(m_axis_tdata[52:49]));
					check_field("notify_start", 32'(want.notify_start),
						32'(m_axis_tdata[53]));
					check_field("notify_time", want.notify_time, m_axis_tdata[85:54]);
					n_results++;
					if (want.status == frd_pkg::ST_ACCEPTED && want.tx_valid)
						n_relayed++;
					if (want.status == frd_pkg::ST_SENT)
						n_sent++;
					if (want.status == frd_pkg::ST_RATE_LIMITED)
						n_limited++;
					if (want.status == frd_pkg::ST_DUPLICATE)
						n_dups++;
					if (want.status == frd_pkg::ST_BAD_LENGTH
					    || want.status == frd_pkg::ST_BAD_TYPE)
						n_rejects++;
					if (want.notify_start)
						n_notify++;
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 11);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run if no beat moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$error("no beat accepted for %0d cycles, %0d answers still owed",
				QUIET_LIMIT, pending_results.size());
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Length and type screening, the duplicate ring (including the all-zero store after
	// reset), notification start and clearing, and relaying with the hop count spent.
	task automatic test_rx_checks();
		send_item(rx_item(32'h0, cfg_elen, cfg_mtype, 32'h0, 8'd3));
		send_item(rx_item(32'h1, 8'd0, cfg_mtype, 32'h1234_5678, 8'd3));
		send_item(rx_item(32'h2, 8'd255, cfg_mtype, 32'h1234_5678, 8'd3));
		send_item(rx_item(32'h3, cfg_elen, 8'h00, 32'h1234_5678, 8'd3));
		send_item(rx_item(32'h4, cfg_elen, 8'hFF, 32'h1234_5678, 8'd3));
		send_item(rx_item(32'hFFFF_FFFF, cfg_elen, cfg_mtype, 32'hFFFF_FFFF, 8'd255));
		send_item(rx_item(32'h5, cfg_elen, cfg_mtype, 32'hFFFF_FFFF, 8'd2));
		send_item(rx_item(32'h6, cfg_elen, cfg_mtype, 32'h0000_0001, 8'd0));
		send_item(clear_req(REQ_CLEAR));
		send_item(clear_req(REQ_CLEAR));
		send_item(clear_req(REQ_SPARE));
		send_item(rx_item(32'h8000_0007, cfg_elen, cfg_mtype, 32'h5A5A_A5A5, 8'd1));
	endtask

	// Fills the send history, hits the limit, lets the oldest slot age out exactly at the
	// window, checks that a sent id is remembered and crosses the wrap of the clock.
	task automatic test_local_send_limit();
		for (int k = 0; k < SLOTS; k++)
			send_item(send_req(32'd100 + k, $urandom));
		send_item(send_req(32'd104, 32'hDEAD_0001));
		send_item(send_req(32'd100 + cfg_win, 32'hC0DE_0002));
		send_item(rx_item(32'd40200, cfg_elen, cfg_mtype, 32'hC0DE_0002, 8'd5));
		send_item(send_req(32'hFFFF_FFF0, 32'hC0DE_0003));
		send_item(send_req(32'h0000_0010, 32'hC0DE_0004));
	endtask

	// Register extremes: a zero window never limits, zero repeats and ttl still send, and
	// the all-ones settings are honoured.
	task automatic test_config_extremes();
		wait_idle();
		write_reg(frd_pkg::REG_WINDOW, 31'd0);
		write_reg(frd_pkg::REG_MSG_TYPE, 31'd0);
		write_reg(frd_pkg::REG_EXP_LEN, 31'd0);
		write_reg(frd_pkg::REG_INIT_TTL, 31'd0);
		write_reg(frd_pkg::REG_REPEATS, 31'd0);
		for (int k = 0; k < SLOTS + 2; k++)
			send_item(send_req(32'h0010_0000, 32'hA000_0000 + k));
		send_item(rx_item(32'h0010_0001, 8'd0, 8'h00, 32'h0BAD_F00D, 8'd1));
		wait_idle();
		write_reg(frd_pkg::REG_WINDOW, 31'd1);
		write_reg(frd_pkg::REG_MSG_TYPE, 31'd255);
		write_reg(frd_pkg::REG_EXP_LEN, 31'd255);
		write_reg(frd_pkg::REG_INIT_TTL, 31'd255);
		write_reg(frd_pkg::REG_REPEATS, 31'd15);
		send_item(send_req(32'h0010_0000, 32'hB000_0001));
		send_item(send_req(32'h0010_0001, 32'hB000_0002));
		send_item(rx_item(32'h0010_0002, 8'd255, 8'hFF, 32'h7777_7777, 8'd128));
		wait_idle();
		write_reg(frd_pkg::REG_WINDOW, 31'h7FFF_FFFF);
		for (int k = 0; k < SLOTS; k++)
			send_item(send_req(32'h0020_0000 + k, 32'hC000_0000 + k));
		send_item(send_req(32'h8020_0001, 32'hC000_0010));
		send_item(send_req(32'h8020_0002, 32'hC000_0011));
	endtask

	// Random traffic in phases, each under fresh register values. Most received packets are
	// well formed so that they reach the duplicate ring; ids are often reused from recent
	// traffic, and the clock mostly creeps forward by fractions of the window so that the
	// send limit is met often. The last phase runs without any idling.
	task automatic test_random_traffic();
		relay_req_t  q;
		int unsigned pick;
		logic [31:0] span;
		for (int p = 0; p < 6; p++) begin
			wait_idle();
			if (p == 5)
				gaps_on = 1'b0;
			case ($urandom_range(0, 3))
				0:       write_reg(frd_pkg::REG_WINDOW, 31'($urandom_range(1, 50)));
				1:       write_reg(frd_pkg::REG_WINDOW, 31'd40000);
				2:       write_reg(frd_pkg::REG_WINDOW, 31'($urandom_range(1, 32'h7FFF_FFFF)));
				default: write_reg(frd_pkg::REG_WINDOW, 31'($urandom_range(100, 5000)));
			endcase
			write_reg(frd_pkg::REG_MSG_TYPE, 31'($urandom_range(0, 255)));
			write_reg(frd_pkg::REG_EXP_LEN, 31'($urandom_range(0, 255)));
			write_reg(frd_pkg::REG_INIT_TTL, 31'($urandom_range(0, 255)));
			write_reg(frd_pkg::REG_REPEATS, 31'($urandom_range(0, 15)));
			repeat (225) begin
				pick = $urandom_range(0, 99);
				span = {1'b0, cfg_win} / 3;
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: clock_ms += $urandom_range(0, span);
					6:                clock_ms += {1'b0, cfg_win};
					7:                clock_ms += {1'b0, cfg_win} - 32'd1;
					8:                clock_ms = $urandom;
					default: ;
				endcase
				q.now   = clock_ms;
				q.len   = cfg_elen;
				q.ptype = cfg_mtype;
				q.hops  = 8'($urandom_range(1, 255));
				q.id    = $urandom;
				if (pick < 50) begin
					q.req = frd_pkg::REQ_RX;
					if ($urandom_range(0, 9) == 0)
						q.len = 8'($urandom_range(0, 255));
					if ($urandom_range(0, 9) == 0)
						q.ptype = 8'($urandom_range(0, 255));
					if ($urandom_range(0, 6) == 0)
						q.hops = 8'd0;
					if (recent_ids.size() != 0 && $urandom_range(0, 99) < 45)
						q.id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
					else if ($urandom_range(0, 49) == 0)
						q.id = 32'h0;
				end else if (pick < 82) begin
					q.req   = frd_pkg::REQ_SEND;
					q.len   = 8'($urandom_range(0, 255));
					q.ptype = 8'($urandom_range(0, 255));
					q.hops  = 8'($urandom_range(0, 255));
					if (recent_ids.size() != 0 && $urandom_range(0, 9) == 0)
						q.id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
				end else begin
					// Clear requests carry random payloads that the block must ignore.
					q.req   = (pick < 96) ? REQ_CLEAR : REQ_SPARE;
					q.len   = 8'($urandom_range(0, 255));
					q.ptype = 8'($urandom_range(0, 255));
					q.hops  = 8'($urandom_range(0, 255));
				end
				if (q.req == frd_pkg::REQ_RX || q.req == frd_pkg::REQ_SEND) begin
					recent_ids.push_back(q.id);
					if (recent_ids.size() > 48)
						void'(recent_ids.pop_front());
				end
				send_item(q);
			end
		end
	endtask

	initial begin
		cfg_win     = frd_pkg::WINDOW_RESET;
		cfg_mtype   = frd_pkg::MSG_TYPE_RESET;
		cfg_elen    = frd_pkg::EXP_LEN_RESET;
		cfg_ttl     = frd_pkg::INIT_TTL_RESET;
		cfg_reps    = frd_pkg::REPEATS_RESET;
		foreach (seen_ids[i])
			seen_ids[i] = 32'h0;
		foreach (slot_live[i]) begin
			slot_live[i] = 1'b0;
			slot_time[i] = 32'h0;
		end
		seen_wr     = 0;
		slot_wr     = 0;
		notify_live = 1'b0;
		clock_ms    = $urandom;
		gaps_on     = 1'b1;
		n_fail      = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_rx_checks();
		test_local_send_limit();
		test_config_extremes();
		test_random_traffic();

		// Let the last answers drain, then wait long enough for a full scan to
		// show any stray beat.
		wait_idle();
		repeat (HIST + 8) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d answers never arrived", pending_results.size());
			n_fail++;
		end
		$display("Run covered %0d requests and %0d answers: %0d relays, %0d local sends,",
			n_items, n_results, n_relayed, n_sent);
		$display("%0d rate limited, %0d duplicates, %0d malformed, %0d notifications started.",
			n_limited, n_dups, n_rejects, n_notify);
		if (n_fail == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
